// File: hw/rtl/msp_pkg.sv
package msp_pkg;

	// graph geometry and arithmetic widths
	localparam int STAGE_SLOTS = 16;
	localparam int WEIGHT_BITS = 16;
	localparam int COST_BITS   = 31;

	// fixed field widths of the stream items
	localparam int SLOT_FIELD_W   = 4;
	localparam int WEIGHT_FIELD_W = 16;
	localparam int PATH_COST_W    = 31;
	localparam int IN_DATA_W      = 24;
	localparam int IN_USER_W      = 3;
	localparam int OUT_DATA_W     = 32;

	localparam int SLOT_W = (STAGE_SLOTS > 1) ? $clog2(STAGE_SLOTS) : 1;
	localparam int IDX_W  = (SLOT_W > SLOT_FIELD_W) ? SLOT_W : SLOT_FIELD_W;
	localparam int SUM_W  = COST_BITS + 1;

	typedef logic [COST_BITS-1:0] cost_t;

	// all ones: no path
	localparam cost_t UNREACH = '1;

	localparam logic [WEIGHT_FIELD_W-1:0] WEIGHT_MASK =
		WEIGHT_FIELD_W'((64'd1 << WEIGHT_BITS) - 64'd1);

	typedef struct packed {
		logic [SLOT_FIELD_W-1:0]   src_slot;
		logic [SLOT_FIELD_W-1:0]   dst_slot;
		logic [WEIGHT_FIELD_W-1:0] weight;
		logic                      edge_present;
		logic                      graph_start;
		logic                      stage_end;
		logic                      graph_end;
	} item_t;

	typedef struct packed {
		logic [PATH_COST_W-1:0] path_cost;
		logic                   reachable;
	} result_t;

endpackage

// File: hw/rtl/msp_cost_core.sv
// Cost register files and the per-edge relax step (read, add, saturate, compare, write).
module msp_cost_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  msp_pkg::item_t   item,
	output msp_pkg::result_t result
);

	msp_pkg::cost_t prev_q [msp_pkg::STAGE_SLOTS];
	msp_pkg::cost_t cur_q  [msp_pkg::STAGE_SLOTS];
	msp_pkg::cost_t cur_nx [msp_pkg::STAGE_SLOTS];

	logic [msp_pkg::IDX_W-1:0]  src_ext;
	logic [msp_pkg::IDX_W-1:0]  dst_ext;
	logic [msp_pkg::SLOT_W-1:0] src_idx;
	logic [msp_pkg::SLOT_W-1:0] dst_idx;
	logic                       in_range;
	msp_pkg::cost_t             prev_rd;
	msp_pkg::cost_t             cur_rd;
	logic [msp_pkg::SUM_W-1:0]  sum;
	msp_pkg::cost_t             cand;
	logic                       take;
	msp_pkg::cost_t             cost0;

	assign src_ext  = msp_pkg::IDX_W'(item.src_slot);
	assign dst_ext  = msp_pkg::IDX_W'(item.dst_slot);
	assign src_idx  = src_ext[msp_pkg::SLOT_W-1:0];
	assign dst_idx  = dst_ext[msp_pkg::SLOT_W-1:0];
	assign in_range = (int'(src_ext) < msp_pkg::STAGE_SLOTS) &&
		(int'(dst_ext) < msp_pkg::STAGE_SLOTS);

	// graph start acts before the edge: previous reads as zero, current as unreachable
	assign prev_rd = item.graph_start ? '0 : prev_q[src_idx];
	assign cur_rd  = item.graph_start ? msp_pkg::UNREACH : cur_q[dst_idx];

	assign sum  = {1'b0, prev_rd} + msp_pkg::SUM_W'(item.weight & msp_pkg::WEIGHT_MASK);
	assign cand = (sum >= {1'b0, msp_pkg::UNREACH}) ? msp_pkg::UNREACH :
		sum[msp_pkg::COST_BITS-1:0];
	assign take = item.edge_present && in_range && (cand < cur_rd);

	always_comb begin
		for (int i = 0; i < msp_pkg::STAGE_SLOTS; i++) begin
			if (take && (dst_idx == msp_pkg::SLOT_W'(i))) begin
				cur_nx[i] = cand;
			end else if (item.graph_start) begin
				cur_nx[i] = msp_pkg::UNREACH;
			end else begin
				cur_nx[i] = cur_q[i];
			end
		end
	end

	// slot zero after the edge, before any stage shift
	assign cost0            = cur_nx[0];
	assign result.path_cost = msp_pkg::PATH_COST_W'(cost0);
	assign result.reachable = (cost0 != msp_pkg::UNREACH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < msp_pkg::STAGE_SLOTS; i++) begin
				prev_q[i] <= '0;
				cur_q[i]  <= msp_pkg::UNREACH;
			end
		end else if (fire) begin
			for (int i = 0; i < msp_pkg::STAGE_SLOTS; i++) begin
				if (item.stage_end) begin
					prev_q[i] <= cur_nx[i];
					cur_q[i]  <= msp_pkg::UNREACH;
				end else begin
					if (item.graph_start) begin
						prev_q[i] <= '0;
					end
					cur_q[i] <= cur_nx[i];
				end
			end
		end
	end

`ifndef SYNTH
	a_shift_clears_cur: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.stage_end |=> cur_q[0] == msp_pkg::UNREACH)
		else $error("current costs not cleared on stage shift");

	a_start_clears_prev: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.graph_start && !item.stage_end |=> prev_q[0] == '0)
		else $error("previous costs not cleared on graph start");

	a_cur_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !item.graph_start && !item.stage_end |=> cur_q[0] <= $past(cur_q[0]))
		else $error("current cost grew within a stage");
`endif

endmodule

// File: hw/rtl/multistage_shortest_path.sv
// Multistage graph shortest path. Edges of a layered graph stream in one per transfer, stage
// by stage; each relaxes the best cost of its target slot (at most 16 slots per stage) with
// the source slot's cost plus the weight, sums saturating at the all-ones unreachable value.
// graph_start (tuser[1]) clears the previous stage to zero before its edge is used,
// stage_end (tuser[2]) moves current costs to previous after the edge, and graph_end (tlast)
// returns one result: the cost of slot zero of the final stage, with tuser set when a path
// exists. Edges with edge_present (tuser[0]) low are ignored but their flags still act. One
// transfer is taken every cycle, except while a graph_end edge waits for the result slot; an
// edge sits in the input register, where the relax step reads and writes the cost registers
// in the same cycle, and the result of a graph_end edge is then held in the output register.
// The output register lets the input keep flowing while a result waits. Only a stalled result
// blocks the next graph_end edge, and with it the input.
module multistage_shortest_path (
	input  logic                            clk,
	input  logic                            arst_n,
	// edge input
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [msp_pkg::IN_DATA_W-1:0]   s_tdata,  // src_slot[3:0], dst_slot[7:4], weight[23:8]
	input  logic [msp_pkg::IN_USER_W-1:0]   s_tuser,  // edge_present[0], graph_start[1], stage_end[2]
	input  logic                            s_tlast,  // graph_end
	// result output
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [msp_pkg::OUT_DATA_W-1:0]  m_tdata,  // path_cost[30:0], zero pad[31]
	output logic                            m_tuser   // reachable
);

	// input register
	msp_pkg::item_t   item_s1;
	logic             valid_s1;
	msp_pkg::item_t   in_item;

	// result register
	msp_pkg::result_t res_q;
	logic             res_valid_q;
	msp_pkg::result_t res_nx;

	logic fire;
	logic out_free;

	assign in_item.src_slot     = s_tdata[3:0];
	assign in_item.dst_slot     = s_tdata[7:4];
	assign in_item.weight       = s_tdata[23:8];
	assign in_item.edge_present = s_tuser[0];
	assign in_item.graph_start  = s_tuser[1];
	assign in_item.stage_end    = s_tuser[2];
	assign in_item.graph_end    = s_tlast;

	// result slot is free if empty or being drained this cycle
	assign out_free = !res_valid_q || m_tready;
	// only an edge that emits waits for the result slot
	assign fire     = valid_s1 && (!item_s1.graph_end || out_free);
	assign s_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= in_item;
		end
	end

	msp_cost_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.result (res_nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= fire && item_s1.graph_end;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && fire && item_s1.graph_end) begin
			res_q <= res_nx;
		end
	end

	assign m_tvalid = res_valid_q;
	assign m_tdata  = msp_pkg::OUT_DATA_W'(res_q.path_cost);
	assign m_tuser  = res_q.reachable;

`ifndef SYNTH
	a_result_from_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(fire && item_s1.graph_end))
		else $error("result appeared without a graph end edge");

	a_end_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item_s1.graph_end |=> m_tvalid)
		else $error("graph end edge gave no result");

	a_held_edge_stays: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !fire |=> valid_s1 && $stable(item_s1))
		else $error("stalled edge lost from input register");
`endif

endmodule

// File: tb/sv/multistage_shortest_path_test.sv
module multistage_shortest_path_test;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEMS       = 1300;  // random edge transfers after the directed tour
	localparam int CALM_TAIL   = 150;   // last transfers run without any idling
	localparam int SQUEEZE_AT  = 700;   // receiver cycle at which the long hold-off starts
	localparam int SQUEEZE_LEN = 200;
	localparam int STALL_LIMIT = 2000;  // cycles with no transfer on either side

	// one row of the directed tour; a pinned row carries its result typed in
	typedef struct {
		msp_pkg::item_t   e;
		bit               pinned;
		msp_pkg::result_t res;
	} edge_row_t;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [msp_pkg::IN_DATA_W-1:0]   s_tdata;   // src_slot[3:0], dst_slot[7:4], weight[23:8]
	logic [msp_pkg::IN_USER_W-1:0]   s_tuser;   // edge_present[0], graph_start[1], stage_end[2]
	logic                            s_tlast;   // graph_end
	logic                            m_tvalid;
	logic                            m_tready;
	logic [msp_pkg::OUT_DATA_W-1:0]  m_tdata;   // path_cost[30:0], zero pad[31]
	logic                            m_tuser;   // reachable

	// predictor state: best cost per slot of the previous and the current stage
	msp_pkg::cost_t prev_cost [msp_pkg::STAGE_SLOTS];
	msp_pkg::cost_t cur_cost  [msp_pkg::STAGE_SLOTS];

	msp_pkg::result_t cost_q[$];     // path costs still owed by the block
	edge_row_t        pinned_q[$];   // rows on offer, in transfer order
	edge_row_t        tour[$];

	int  errors = 0;
	int  sent = 0;
	int  idle_cycles = 0;
	bit  calm = 1'b0;

	always #10 clk = ~clk;

	multistage_shortest_path u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// Min-plus relax of one edge. Order within an item: clear on graph start, relax,
	// take the result (before any shift), then move current costs to previous on
	// stage end. Returns 1 when the edge closes a graph and so owes a result.
	function automatic bit relax_edge(input msp_pkg::item_t e, output msp_pkg::result_t r);
		logic [msp_pkg::SUM_W-1:0] sum;
		if (e.graph_start) begin
			foreach (prev_cost[i]) begin
				prev_cost[i] = '0;
				cur_cost[i]  = msp_pkg::UNREACH;
			end
		end
		if (e.edge_present && int'(e.src_slot) < msp_pkg::STAGE_SLOTS &&
				int'(e.dst_slot) < msp_pkg::STAGE_SLOTS) begin
			sum = msp_pkg::SUM_W'(prev_cost[e.src_slot]) +
				msp_pkg::SUM_W'(e.weight & msp_pkg::WEIGHT_MASK);
			// an unreachable source must stay unreachable, so clamp at all ones
			if (sum >= msp_pkg::SUM_W'(msp_pkg::UNREACH))
				sum = msp_pkg::SUM_W'(msp_pkg::UNREACH);
			if (msp_pkg::cost_t'(sum) < cur_cost[e.dst_slot])
				cur_cost[e.dst_slot] = msp_pkg::cost_t'(sum);
		end
		r.path_cost = cur_cost[0];
		r.reachable = (cur_cost[0] != msp_pkg::UNREACH);
		if (e.stage_end) begin
			foreach (prev_cost[i]) begin
				prev_cost[i] = cur_cost[i];
				cur_cost[i]  = msp_pkg::UNREACH;
			end
		end
		return e.graph_end;
	endfunction

	function automatic edge_row_t edge_row(int src, int dst, int w, bit present, bit gstart,
			bit send, bit gend, bit pinned = 1'b0, int cost = 0, bit reach = 1'b0);
		edge_row_t r;
		r.e.src_slot     = msp_pkg::SLOT_FIELD_W'(src);
		r.e.dst_slot     = msp_pkg::SLOT_FIELD_W'(dst);
		r.e.weight       = msp_pkg::WEIGHT_FIELD_W'(w);
		r.e.edge_present = present;
		r.e.graph_start  = gstart;
		r.e.stage_end    = send;
		r.e.graph_end    = gend;
		r.pinned         = pinned;
		r.res.path_cost  = msp_pkg::PATH_COST_W'(cost);
		r.res.reachable  = reach;
		return r;
	endfunction

	// Offer one edge and hold it until the transfer. An idle gap may come first, except
	// in the calm tail.
	task automatic send_edge(input edge_row_t r);
		int gap;
		if (!calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 3);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pinned_q.push_back(r);
		s_tdata  <= {r.e.weight, r.e.dst_slot, r.e.src_slot};
		s_tuser  <= {r.e.stage_end, r.e.graph_start, r.e.edge_present};
		s_tlast  <= r.e.graph_end;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sent++;
		calm = (sent >= ITEMS - CALM_TAIL);
	endtask

	// Directed tour. After reset every current cost is unreachable and the previous
	// stage is all zero; pinned costs follow by hand from the rows above them.
	initial begin
		int unr;
		unr = int'(msp_pkg::UNREACH);
		tour.push_back(edge_row(0, 0, 0, 0, 0, 0, 1, 1, unr, 0));          // end straight after reset
		tour.push_back(edge_row(0, 0, 0, 1, 1, 0, 1, 1, 0, 1));            // start, zero edge, end
		tour.push_back(edge_row(15, 15, 65535, 1, 1, 1, 0));               // top slots, top weight
		tour.push_back(edge_row(15, 0, 65535, 1, 0, 0, 1, 1, 131070, 1));
		tour.push_back(edge_row(15, 0, 3, 0, 0, 0, 1, 1, 131070, 1));      // absent edge ignored
		tour.push_back(edge_row(0, 0, 1, 1, 0, 0, 1, 1, 131070, 1));       // unreachable source
		tour.push_back(edge_row(15, 5, 0, 1, 0, 1, 0));
		tour.push_back(edge_row(5, 0, 10, 1, 0, 0, 0));
		tour.push_back(edge_row(0, 0, 20, 1, 0, 0, 0));                    // worse, not kept
		tour.push_back(edge_row(5, 0, 9, 1, 0, 0, 1, 1, 65544, 1));        // better, kept
		tour.push_back(edge_row(0, 0, 0, 0, 0, 1, 1, 1, 65544, 1));        // emit comes before shift
		tour.push_back(edge_row(0, 0, 0, 0, 0, 0, 1, 1, unr, 0));          // end with empty stage
		tour.push_back(edge_row(3, 0, 5, 1, 0, 0, 1, 1, unr, 0));          // saturates at all ones
		tour.push_back(edge_row(0, 9, 65535, 1, 0, 1, 0));
		tour.push_back(edge_row(9, 0, 0, 1, 1, 1, 1, 1, 0, 1));            // every flag at once
		tour.push_back(edge_row(10, 6, 'hAAAA, 1, 1, 0, 0));
		tour.push_back(edge_row(5, 10, 'h5555, 1, 0, 1, 0));
		tour.push_back(edge_row(10, 0, 'h5555, 1, 0, 0, 0));
		tour.push_back(edge_row(6, 0, 'hAAAA, 1, 0, 1, 1));
		tour.push_back(edge_row(0, 0, 1, 1, 0, 0, 1));
	end

	// Sender: reset, directed tour, then random graphs with some noise mixed in.
	initial begin
		edge_row_t r;
		int        span;
		int        n_stages;
		int        n_edges;
		bit        closing;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= '0;
		s_tlast  <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (tour[i])
			send_edge(tour[i]);
		sent = 0;
		r.pinned = 1'b0;
		r.res    = '0;
		while (sent < ITEMS) begin
			if ($urandom_range(0, 9) == 0) begin
				// noise: any slots, any weight, flags at random
				r.e.src_slot     = msp_pkg::SLOT_FIELD_W'($urandom);
				r.e.dst_slot     = msp_pkg::SLOT_FIELD_W'($urandom);
				r.e.weight       = msp_pkg::WEIGHT_FIELD_W'($urandom);
				r.e.edge_present = 1'($urandom_range(0, 1));
				r.e.graph_start  = ($urandom_range(0, 7) == 0);
				r.e.stage_end    = ($urandom_range(0, 3) == 0);
				r.e.graph_end    = ($urandom_range(0, 3) == 0);
				send_edge(r);
			end else begin
				// well-formed graph; mostly narrow stages so slot zero is often hit
				span     = ($urandom_range(0, 7) == 0) ? msp_pkg::STAGE_SLOTS :
					$urandom_range(1, 4);
				n_stages = $urandom_range(1, 4);
				for (int st = 0; st < n_stages; st++) begin
					n_edges = $urandom_range(1, 8);
					for (int k = 0; k < n_edges; k++) begin
						closing = (k == n_edges - 1);
						r.e.src_slot = msp_pkg::SLOT_FIELD_W'($urandom_range(0, span - 1));
						r.e.dst_slot = msp_pkg::SLOT_FIELD_W'($urandom_range(0, span - 1));
						case ($urandom_range(0, 7))
							0:       r.e.weight = '0;
							1:       r.e.weight = '1;
							2, 3:    r.e.weight = msp_pkg::WEIGHT_FIELD_W'($urandom_range(0, 15));
							default: r.e.weight = msp_pkg::WEIGHT_FIELD_W'($urandom);
						endcase
						r.e.edge_present = ($urandom_range(0, 9) != 0);
						// now and then the start mark is dropped: costs carry over
						r.e.graph_start  = (st == 0 && k == 0 && $urandom_range(0, 9) != 0);
						r.e.graph_end    = closing && (st == n_stages - 1);
						r.e.stage_end    = closing && (st < n_stages - 1 || $urandom_range(0, 1));
						send_edge(r);
					end
				end
			end
		end
		s_tvalid <= 1'b0;
		while (cost_q.size() > 0)
			@(posedge clk);
		// leave room for a stray result to show
		repeat (8) @(posedge clk);
		if (cost_q.size() != 0) begin
			$error("result missing: %0d still owed", cost_q.size());
			errors++;
		end
		if (errors == 0)
			$display("multistage_shortest_path_test: PASS");
		else
			$display("multistage_shortest_path_test: FAIL");
		$finish;
	end

	// Receiver: short random hold-offs, one long hold-off so that the output
	// register fills and the next graph-end edge stalls the input, then none.
	initial begin
		int hold;
		int rx_cycles;
		hold      = 0;
		rx_cycles = 0;
		m_tready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			rx_cycles++;
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else if (rx_cycles == SQUEEZE_AT) begin
				hold = SQUEEZE_LEN - 1;
				m_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				hold = $urandom_range(1, 3) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
			@(posedge clk);
		end
	end

	// Scoreboard: predict on each edge transfer, check each result transfer
	// against the oldest owed cost, and watch for a hung block.
	always @(posedge clk) begin : scoreboard
		msp_pkg::item_t   e;
		edge_row_t        row;
		msp_pkg::result_t want;
		msp_pkg::result_t got;
		bit               owes;
		bit               moved;
		moved = 1'b0;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				moved          = 1'b1;
				e.src_slot     = s_tdata[3:0];
				e.dst_slot     = s_tdata[7:4];
				e.weight       = s_tdata[23:8];
				e.edge_present = s_tuser[0];
				e.graph_start  = s_tuser[1];
				e.stage_end    = s_tuser[2];
				e.graph_end    = s_tlast;
				row  = pinned_q.pop_front();
				owes = relax_edge(e, want);
				if (owes)
					cost_q.push_back(row.pinned ? row.res : want);
			end
			if (m_tvalid && m_tready) begin
				moved         = 1'b1;
				got.path_cost = m_tdata[msp_pkg::PATH_COST_W-1:0];
				got.reachable = m_tuser;
				if (cost_q.size() == 0) begin
					$error("result transfer with nothing owed: path_cost %0d reachable %0b",
						got.path_cost, got.reachable);
					errors++;
				end else begin
					want = cost_q.pop_front();
					if (got.path_cost !== want.path_cost) begin
						$error("path_cost: expected %0d, got %0d", want.path_cost, got.path_cost);
						errors++;
					end
					if (got.reachable !== want.reachable) begin
						$error("reachable: expected %0b, got %0b", want.reachable, got.reachable);
						errors++;
					end
				end
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("multistage_shortest_path_test: FAIL");
				$finish;
			end
		end
	end

endmodule
